// ===== hdl/ssq_pkg.sv =====
// ----------------------------------------------------------------------------
// ssq_pkg - status relay slot sequencer package
// Shared types, codes and the slot tier function.
// ----------------------------------------------------------------------------
`default_nettype none

package ssq_pkg;

    localparam int MAX_DEVICES_DEF = 16;

    localparam int MAP_W  = 16;
    localparam int SUB_W  = 8;
    localparam int SLOT_W = 8;
    localparam int TIME_W = 32;
    localparam int US_W   = 16;
    localparam int TYPE_W = 8;
    localparam int CIDX_W = 8;
    localparam int CDAT_W = 16;

    localparam logic [15:0] SLOT_PERIOD_RST = 16'd1000;
    localparam logic [15:0] LISTEN_LEAD_RST = 16'd100;
    localparam logic [7:0]  MSG_TYPE_RST    = 8'd0;

    localparam logic [2:0] MODE_BEGIN   = 3'd0;
    localparam logic [2:0] MODE_TX_DONE = 3'd1;
    localparam logic [2:0] MODE_RX_PKT  = 3'd2;
    localparam logic [2:0] MODE_RX_ERR  = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    localparam logic [CIDX_W-1:0] REG_SLOT_PERIOD = 8'd0;
    localparam logic [CIDX_W-1:0] REG_LISTEN_LEAD = 8'd1;
    localparam logic [CIDX_W-1:0] REG_MSG_TYPE    = 8'd2;

    typedef enum logic [2:0] {
        ACT_TX        = 3'd0,
        ACT_LISTEN    = 3'd1,
        ACT_DONE      = 3'd2,
        ACT_COLLISION = 3'd3,
        ACT_NOTHING   = 3'd4
    } act_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_RANK,
        C_TIME,
        C_OUT
    } ctl_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_ADD,
        T_SUB
    } tmr_state_t;

    typedef struct packed {
        logic              start;
        logic [SLOT_W-1:0] mine;
        logic [MAP_W-1:0]  heard;
        logic [SLOT_W-1:0] nearest;
    } rank_req_t;

    typedef struct packed {
        logic start;
        logic listen;
    } tmr_req_t;

    // 2 nearest device, 1 heard by master, 0 otherwise
    function automatic logic [1:0] tier_of(
        input logic [SLOT_W-1:0] s,
        input logic [MAP_W-1:0]  heard,
        input logic [SLOT_W-1:0] nearest
    );
        logic [1:0] t;
        t = 2'd0;
        if (s != '0 && s == nearest)
            t = 2'd2;
        else if (s < SLOT_W'(MAP_W) && heard[s[3:0]])
            t = 2'd1;
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ssq_rank.sv =====
// ----------------------------------------------------------------------------
// ssq_rank - transmit position ranking
// Visits one slot per cycle and counts slots ranked ahead of own slot.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_rank #(
    parameter int MAX_DEVICES = ssq_pkg::MAX_DEVICES_DEF,
    parameter int CW          = $clog2(MAX_DEVICES + 1)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ssq_pkg::rank_req_t         req,
    input  wire logic [CW-1:0]              total,
    output logic                            done,
    output logic [ssq_pkg::SLOT_W-1:0]      position
);

    logic                         busy_reg,  busy_next;
    logic                         done_reg,  done_next;
    logic [CW-1:0]                s_reg,     s_next;
    logic [CW-1:0]                total_reg, total_next;
    logic [ssq_pkg::SLOT_W-1:0]   idx_reg,   idx_next;
    logic [ssq_pkg::SLOT_W-1:0]   mine_reg,  mine_next;
    logic [1:0]                   tier_reg,  tier_next;
    logic [ssq_pkg::MAP_W-1:0]    heard_reg, heard_next;
    logic [ssq_pkg::SLOT_W-1:0]   near_reg,  near_next;
    logic [ssq_pkg::SLOT_W-1:0]   s_ext;
    logic [1:0]                   ts;

    assign s_ext = ssq_pkg::SLOT_W'(s_reg);
    assign ts    = ssq_pkg::tier_of(s_ext, heard_reg, near_reg);

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        s_next     = s_reg;
        total_next = total_reg;
        idx_next   = idx_reg;
        mine_next  = mine_reg;
        tier_next  = tier_reg;
        heard_next = heard_reg;
        near_next  = near_reg;
        if (req.start)
        begin
            mine_next  = req.mine;
            heard_next = req.heard;
            near_next  = req.nearest;
            total_next = total;
            s_next     = CW'(1);
            tier_next  = ssq_pkg::tier_of(req.mine, req.heard, req.nearest);
            if (req.mine == '0)
            begin
                idx_next  = ssq_pkg::SLOT_W'(total);
                done_next = 1'b1;
            end
            else
            begin
                idx_next  = ssq_pkg::SLOT_W'(1);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            if (s_reg >= total_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (s_ext != mine_reg)
                begin
                    if (ts != tier_reg)
                    begin
                        if (ts < tier_reg)
                            idx_next = idx_reg + 1'b1;
                    end
                    else if (s_ext > mine_reg)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                s_next = s_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg     <= s_next;
        total_reg <= total_next;
        idx_reg   <= idx_next;
        mine_reg  <= mine_next;
        tier_reg  <= tier_next;
        heard_reg <= heard_next;
        near_reg  <= near_next;
    end

    assign done     = done_reg;
    assign position = idx_reg;

endmodule

`default_nettype wire

// ===== hdl/ssq_timer.sv =====
// ----------------------------------------------------------------------------
// ssq_timer - slot time unit
// Multiplies slot offset by period, then adds phase start and, for listen
// requests, takes off the listen lead on one shared 32-bit adder.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_timer #(
    parameter int CW = 5
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire ssq_pkg::tmr_req_t           req,
    input  wire logic [CW-1:0]               pos,
    input  wire logic [ssq_pkg::US_W-1:0]    period,
    input  wire logic [ssq_pkg::US_W-1:0]    lead,
    input  wire logic [ssq_pkg::TIME_W-1:0]  phase,
    output logic                             done,
    output logic [ssq_pkg::TIME_W-1:0]       when
);

    localparam int PW = CW + ssq_pkg::US_W;

    ssq_pkg::tmr_state_t          state_reg, state_next;
    logic                         done_reg,  done_next;
    logic                         listen_reg, listen_next;
    logic [PW-1:0]                prod_reg,  prod_next;
    logic [ssq_pkg::TIME_W-1:0]   acc_reg,   acc_next;
    logic [ssq_pkg::TIME_W-1:0]   op_a, op_b, sum;
    logic                         cin;

    always_comb
    begin
        op_a = acc_reg;
        op_b = ~ssq_pkg::TIME_W'(lead);
        cin  = 1'b1;
        if (state_reg == ssq_pkg::T_ADD)
        begin
            op_a = phase;
            op_b = ssq_pkg::TIME_W'(prod_reg);
            cin  = 1'b0;
        end
        sum = op_a + op_b + ssq_pkg::TIME_W'(cin);
    end

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        listen_next = listen_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        unique case (state_reg)
            ssq_pkg::T_IDLE:
            begin
                if (req.start)
                begin
                    prod_next   = PW'(pos - CW'(1)) * PW'(period);
                    listen_next = req.listen;
                    state_next  = ssq_pkg::T_ADD;
                end
            end
            ssq_pkg::T_ADD:
            begin
                acc_next = sum;
                if (listen_reg)
                begin
                    state_next = ssq_pkg::T_SUB;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ssq_pkg::T_IDLE;
                end
            end
            ssq_pkg::T_SUB:
            begin
                acc_next   = sum;
                done_next  = 1'b1;
                state_next = ssq_pkg::T_IDLE;
            end
            default:
            begin
                state_next = ssq_pkg::T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssq_pkg::T_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        listen_reg <= listen_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
    end

    assign done = done_reg;
    assign when = acc_reg;

endmodule

`default_nettype wire

// ===== hdl/status_relay_slot_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// status_relay_slot_sequencer_unit - status broadcast slot sequencer
// Begin items pass through the ranking unit, which visits one slot per cycle,
// then through the slot time unit. Advance items giving transmit or listen pass
// through the slot time unit; others go straight to the result register.
// One item at a time; input is ready again the cycle after the result is
// loaded, and the next item is taken while a result waits at the output.
// Reset clears all round state and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module status_relay_slot_sequencer_unit #(
    parameter int MAX_DEVICES = ssq_pkg::MAX_DEVICES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  mode,
    input  wire logic [7:0]  own_slot,
    input  wire logic [7:0]  slot_count,
    input  wire logic [31:0] start_time,
    input  wire logic [15:0] master_map,
    input  wire logic [7:0]  master_nearest,
    input  wire logic [15:0] ranging_heard,
    input  wire logic [7:0]  overheard_subscriber,
    input  wire logic [7:0]  msg_type,
    input  wire logic [7:0]  source_slot,
    input  wire logic [15:0] sender_heard,
    input  wire logic [7:0]  sender_subscriber,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       action,
    output logic [31:0]      action_time,
    output logic [15:0]      heard_map,
    output logic [15:0]      direct_map,
    output logic [7:0]       pending_id
);

    localparam int CW = $clog2(MAX_DEVICES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DEVICES);

    // configuration
    logic [15:0] period_reg;
    logic [15:0] lead_reg;
    logic [7:0]  type_reg;

    // round state
    ssq_pkg::ctl_state_t   state_reg,   state_next;
    logic [CW-1:0]         pos_reg,     pos_next;
    logic [CW-1:0]         total_reg,   total_next;
    logic [7:0]            tx_reg,      tx_next;
    logic [31:0]           phase_reg,   phase_next;
    logic [15:0]           present_reg, present_next;
    logic [15:0]           first_reg,   first_next;
    logic [7:0]            pend_reg,    pend_next;
    ssq_pkg::act_t         act_reg,     act_next;
    logic [31:0]           time_reg,    time_next;
    logic                  tstart_reg,  tstart_next;

    // result register
    logic                  ovalid_reg,  ovalid_next;
    ssq_pkg::act_t         oact_reg,    oact_next;
    logic [31:0]           otime_reg,   otime_next;
    logic [15:0]           omap_reg,    omap_next;
    logic [15:0]           odir_reg,    odir_next;
    logic [7:0]            opend_reg,   opend_next;

    logic                  in_acc;
    logic [CW-1:0]         adv_pos;
    logic [CW-1:0]         cnt_sat;
    logic [15:0]           snd_bit;
    logic [15:0]           own_bit;

    ssq_pkg::rank_req_t    rank_req;
    logic                  rank_done;
    logic [7:0]            rank_pos;
    ssq_pkg::tmr_req_t     tmr_req;
    logic                  tmr_done;
    logic [31:0]           tmr_when;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ssq_pkg::C_IDLE);
    assign in_acc    = in_valid && in_ready;

    assign cnt_sat = (slot_count > 8'(MAX_DEVICES)) ? MAX_CNT : CW'(slot_count);
    assign adv_pos = (pos_reg < total_reg) ? pos_reg + 1'b1 : pos_reg;
    assign snd_bit = (source_slot < 8'(MAX_DEVICES)) ? (16'd1 << source_slot[3:0]) : 16'd0;
    assign own_bit = (own_slot < 8'(MAX_DEVICES)) ? (16'd1 << own_slot[3:0]) : 16'd0;

    assign rank_req.start   = in_acc && (mode == ssq_pkg::MODE_BEGIN);
    assign rank_req.mine    = own_slot;
    assign rank_req.heard   = master_map;
    assign rank_req.nearest = master_nearest;

    assign tmr_req.start  = tstart_reg;
    assign tmr_req.listen = (act_reg == ssq_pkg::ACT_LISTEN);

    ssq_rank #(
        .MAX_DEVICES (MAX_DEVICES),
        .CW          (CW)
    ) u_rank (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (rank_req),
        .total    (cnt_sat),
        .done     (rank_done),
        .position (rank_pos)
    );

    ssq_timer #(
        .CW (CW)
    ) u_timer (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (tmr_req),
        .pos    (pos_reg),
        .period (period_reg),
        .lead   (lead_reg),
        .phase  (phase_reg),
        .done   (tmr_done),
        .when   (tmr_when)
    );

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        total_next   = total_reg;
        tx_next      = tx_reg;
        phase_next   = phase_reg;
        present_next = present_reg;
        first_next   = first_reg;
        pend_next    = pend_reg;
        act_next     = act_reg;
        time_next    = time_reg;
        tstart_next  = 1'b0;
        ovalid_next  = ovalid_reg && !out_ready;
        oact_next    = oact_reg;
        otime_next   = otime_reg;
        omap_next    = omap_reg;
        odir_next    = odir_reg;
        opend_next   = opend_reg;

        unique case (state_reg)
            ssq_pkg::C_IDLE:
            begin
                if (in_acc)
                begin
                    time_next  = '0;
                    state_next = ssq_pkg::C_OUT;
                    act_next   = ssq_pkg::ACT_NOTHING;
                    case (mode) inside
                        ssq_pkg::MODE_BEGIN:
                        begin
                            pos_next     = CW'(1);
                            total_next   = cnt_sat;
                            phase_next   = start_time;
                            present_next = ranging_heard | own_bit;
                            first_next   = ranging_heard;
                            pend_next    = overheard_subscriber;
                            state_next   = ssq_pkg::C_RANK;
                        end
                        ssq_pkg::MODE_TX_DONE, ssq_pkg::MODE_RX_ERR, ssq_pkg::MODE_RX_PKT:
                        begin
                            if (mode == ssq_pkg::MODE_RX_PKT && msg_type != type_reg)
                            begin
                                act_next = ssq_pkg::ACT_COLLISION;
                            end
                            else
                            begin
                                if (mode == ssq_pkg::MODE_RX_PKT)
                                begin
                                    first_next   = first_reg | snd_bit;
                                    present_next = present_reg | snd_bit | sender_heard;
                                    if (pend_reg == '0)
                                        pend_next = sender_subscriber;
                                end
                                pos_next = adv_pos;
                                if (adv_pos >= total_reg)
                                begin
                                    act_next = ssq_pkg::ACT_DONE;
                                end
                                else
                                begin
                                    act_next    = (8'(adv_pos) == tx_reg) ?
                                                  ssq_pkg::ACT_TX : ssq_pkg::ACT_LISTEN;
                                    tstart_next = 1'b1;
                                    state_next  = ssq_pkg::C_TIME;
                                end
                            end
                        end
                        ssq_pkg::MODE_CLEAR:
                        begin
                            present_next = '0;
                            first_next   = '0;
                            pend_next    = '0;
                        end
                        default:
                        begin
                            act_next = ssq_pkg::ACT_NOTHING;
                        end
                    endcase
                end
            end
            ssq_pkg::C_RANK:
            begin
                if (rank_done)
                begin
                    tx_next     = rank_pos;
                    act_next    = (rank_pos == 8'd1) ? ssq_pkg::ACT_TX : ssq_pkg::ACT_LISTEN;
                    tstart_next = 1'b1;
                    state_next  = ssq_pkg::C_TIME;
                end
            end
            ssq_pkg::C_TIME:
            begin
                if (tmr_done)
                begin
                    time_next  = tmr_when;
                    state_next = ssq_pkg::C_OUT;
                end
            end
            ssq_pkg::C_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    oact_next   = act_reg;
                    otime_next  = time_reg;
                    omap_next   = present_reg;
                    odir_next   = first_reg;
                    opend_next  = pend_reg;
                    state_next  = ssq_pkg::C_IDLE;
                end
            end
            default:
            begin
                state_next = ssq_pkg::C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= ssq_pkg::SLOT_PERIOD_RST;
            lead_reg   <= ssq_pkg::LISTEN_LEAD_RST;
            type_reg   <= ssq_pkg::MSG_TYPE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ssq_pkg::REG_SLOT_PERIOD: period_reg <= cfg_data;
                ssq_pkg::REG_LISTEN_LEAD: lead_reg   <= cfg_data;
                ssq_pkg::REG_MSG_TYPE:    type_reg   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ssq_pkg::C_IDLE;
            pos_reg     <= '0;
            total_reg   <= '0;
            tx_reg      <= '0;
            phase_reg   <= '0;
            present_reg <= '0;
            first_reg   <= '0;
            pend_reg    <= '0;
            act_reg     <= ssq_pkg::ACT_NOTHING;
            time_reg    <= '0;
            tstart_reg  <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            total_reg   <= total_next;
            tx_reg      <= tx_next;
            phase_reg   <= phase_next;
            present_reg <= present_next;
            first_reg   <= first_next;
            pend_reg    <= pend_next;
            act_reg     <= act_next;
            time_reg    <= time_next;
            tstart_reg  <= tstart_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oact_reg  <= oact_next;
        otime_reg <= otime_next;
        omap_reg  <= omap_next;
        odir_reg  <= odir_next;
        opend_reg <= opend_next;
    end

    assign out_valid   = ovalid_reg;
    assign action      = oact_reg;
    assign action_time = otime_reg;
    assign heard_map   = omap_reg;
    assign direct_map  = odir_reg;
    assign pending_id  = opend_reg;

endmodule

`default_nettype wire
